[src/spp_pkg.sv]
`timescale 1ns / 1ps
// Package for the stable pivot partition block.
// Holds queue sizing constants and the output load record; no dependencies.
package spp_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int VAL_W       = 32;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Request from the sequencer to fill the output register
	typedef struct packed {
		logic                    load;
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    overflow;
	} spp_load_t;

endpackage

[src/spp_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the stable pivot partition block: one element per item.
// Depends on spp_pkg for the value width.
interface spp_in_if import spp_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

[src/spp_out_if.sv]
`timescale 1ns / 1ps
// Output channel of the stable pivot partition block: one result per item.
// Depends on spp_pkg for the value width.
interface spp_out_if import spp_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_res;
	logic                    last_res;
	logic                    overflow;

	modport source (output valid, output value_res, output last_res, output overflow,
		input ready);
	modport sink   (input valid, input value_res, input last_res, input overflow,
		output ready);
endinterface

[src/spp_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No package dependencies.
module spp_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; hold the data while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/spp_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the stable pivot partition block: pivot capture, queue fill and drain.
// Depends on spp_pkg; drives the queue RAM ports and the output load record.
module spp_ctrl import spp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    elem_valid,
	input  logic signed [VAL_W-1:0] elem_value,
	input  logic                    elem_last,
	output logic                    elem_ready,
	input  logic                    can_load,
	output spp_load_t               load,
	output logic                    wr_en,
	output logic [IDX_W-1:0]        wr_addr,
	output logic [VAL_W-1:0]        wr_data,
	output logic                    rd_en,
	output logic [IDX_W-1:0]        rd_addr,
	input  logic [VAL_W-1:0]        rd_data
);

	localparam logic [1:0] S_IN    = 2'd0;
	localparam logic [1:0] S_PIVOT = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]              state_q, state_d;
	logic signed [VAL_W-1:0] pivot_q;
	logic                    taken_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    drop_q;
	logic [IDX_W-1:0]        rd_idx_q;

	logic             accept;
	logic             below;
	logic             room;
	logic             fin;
	logic [CNT_W-1:0] rd_next;

	assign elem_ready = (state_q == S_IN) && can_load;
	assign accept     = elem_valid && elem_ready;
	assign below      = elem_value < pivot_q;
	assign room       = cnt_q < CNT_W'(QUEUE_DEPTH);
	assign rd_next    = CNT_W'(rd_idx_q) + CNT_W'(1);
	assign fin        = (rd_next == cnt_q);

	// Queue write on a large element while space remains
	assign wr_en   = accept && taken_q && !below && room;
	assign wr_addr = cnt_q[IDX_W-1:0];
	assign wr_data = elem_value;

	// Queue read: head on the pivot result, then one ahead per drained entry
	assign rd_addr = (state_q == S_PIVOT) ? '0 : rd_next[IDX_W-1:0];
	assign rd_en   = can_load && (((state_q == S_PIVOT) && (cnt_q != '0)) ||
		((state_q == S_DRAIN) && !fin));

	// Output load selection
	always_comb begin
		load = '0;
		unique case (state_q)
			S_IN: begin
				if (accept && (!taken_q ? elem_last : below)) begin
					load.load  = 1'b1;
					load.value = elem_value;
					load.last  = !taken_q;
				end
			end
			S_PIVOT: begin
				load.load     = can_load;
				load.value    = pivot_q;
				load.last     = (cnt_q == '0);
				load.overflow = (cnt_q == '0) && drop_q;
			end
			S_DRAIN: begin
				load.load     = can_load;
				load.value    = $signed(rd_data);
				load.last     = fin;
				load.overflow = fin && drop_q;
			end
			default: begin
				load = '0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IN: begin
				if (accept && taken_q && elem_last) begin
					state_d = S_PIVOT;
				end
			end
			S_PIVOT: begin
				if (can_load) begin
					state_d = (cnt_q == '0) ? S_IN : S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (can_load && fin) begin
					state_d = S_IN;
				end
			end
			default: begin
				state_d = S_IN;
			end
		endcase
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IN;
			pivot_q  <= '0;
			taken_q  <= 1'b0;
			cnt_q    <= '0;
			drop_q   <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !taken_q) begin
				pivot_q <= elem_value;
				taken_q <= !elem_last;
				cnt_q   <= '0;
				drop_q  <= 1'b0;
			end else if (accept && !below) begin
				if (room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (state_q == S_PIVOT && can_load) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_next[IDX_W-1:0];
			end
			// End of sequence: clear for the next pivot
			if (load.load && load.last && state_q != S_IN) begin
				taken_q <= 1'b0;
				cnt_q   <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_wr_only_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_IN) && !rd_en)
		else $error("queue write outside fill phase");

	a_last_ends_seq: assert property (@(posedge clk) disable iff (!arst_n)
		load.load && load.last |=> (state_q == S_IN) && !taken_q)
		else $error("sequence not closed after final result");

	a_ovf_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		load.load && !load.last |-> !load.overflow)
		else $error("overflow flagged on a non-final result");

endmodule

[src/stable_pivot_partition.sv]
`timescale 1ns / 1ps
// Stable partition of a signed stream around its first element (the pivot).
// Throughput: one element per cycle while filling and the output is not stalled; an item's
// result, if any, is registered in the cycle after acceptance. The final item is followed
// by the pivot, then the queued entries, paced by the single registered queue read port.
// Reset: arst_n clears control state; the queue RAM is not cleared and needs no sweep.
module stable_pivot_partition import spp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	spp_in_if.sink    elem,
	spp_out_if.source res
);

	spp_load_t        load;
	logic             can_load;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [VAL_W-1:0] rd_data;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_last_q;
	logic                    out_ovf_q;

	assign can_load = !out_valid_q || res.ready;

	spp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (elem.valid),
		.elem_value (elem.value),
		.elem_last  (elem.last),
		.elem_ready (elem.ready),
		.can_load   (can_load),
		.load       (load),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data)
	);

	spp_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (VAL_W)
	) u_queue (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load.load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load.load) begin
			out_value_q <= load.value;
			out_last_q  <= load.last;
			out_ovf_q   <= load.overflow;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.value_res = out_value_q;
	assign res.last_res  = out_last_q;
	assign res.overflow  = out_ovf_q;

endmodule
